/* rtl/aes256_counter_block_mixer_macros.svh */
// Assertion macros for the checker file.
`ifndef AES256_COUNTER_BLOCK_MIXER_MACROS_SVH
`define AES256_COUNTER_BLOCK_MIXER_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define ACM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acm check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define ACM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("acm check failed");

`endif

/* rtl/acm_pkg.sv */
`default_nettype none
package acm_pkg;

  localparam int ACM_BLOCKS_DEF = 3;
  localparam int ACM_ROUNDS     = 14;

  typedef struct packed {
    logic        end_of_stream;
    logic [63:0] counter_high;
    logic [63:0] counter_low;
    logic [63:0] key_word_3;
    logic [63:0] key_word_2;
    logic [63:0] key_word_1;
    logic [63:0] key_word_0;
  } acm_in_req_t;

  typedef struct packed {
    logic        stream_end;
    logic        last_of_item;
    logic [1:0]  block_index;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } acm_out_req_t;

  // one block in flight: state, key window of eight words, tags
  typedef struct packed {
    logic [127:0] state;
    logic [255:0] win;
    logic [1:0]   idx;
    logic         last;
    logic         eos;
  } acm_stage_t;

  localparam logic [7:0] RCON [0:6] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40};

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    logic [31:0] r;
    for (int i = 0; i < 4; i++) r[8*i +: 8] = SBOX[w[8*i +: 8]];
    return r;
  endfunction

  // byte i of the state sits in bits 8i+7:8i
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[8*(r + 4*c) +: 8] = SBOX[s[8*(r + 4*((c + r) % 4)) +: 8]];
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] t);
    logic [127:0] s;
    logic [7:0]   a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = t[32*c +: 8];
      a1 = t[32*c + 8 +: 8];
      a2 = t[32*c + 16 +: 8];
      a3 = t[32*c + 24 +: 8];
      s[32*c +: 8]      = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      s[32*c + 8 +: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      s[32*c + 16 +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      s[32*c + 24 +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return s;
  endfunction

  // slide the key window on by four words
  function automatic logic [255:0] next_win(input logic [255:0] w, input logic rot,
                                            input logic [7:0] rc);
    logic [31:0] t, n0, n1, n2, n3;
    t  = w[255:224];
    if (rot) t = sub_word({t[7:0], t[31:8]}) ^ {24'h0, rc};
    else     t = sub_word(t);
    n0 = w[31:0] ^ t;
    n1 = w[63:32] ^ n0;
    n2 = w[95:64] ^ n1;
    n3 = w[127:96] ^ n2;
    return {n3, n2, n1, n0, w[255:128]};
  endfunction

endpackage
`default_nettype wire

/* rtl/acm_front.sv */
`default_nettype none
module acm_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire acm_pkg::acm_in_req_t in_req,
  output logic                     q_valid,
  output acm_pkg::acm_in_req_t     q_req,
  input  wire logic                q_pop
);
  import acm_pkg::*;

  acm_in_req_t ent_r [0:1];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = ent_r[rp_r];

  // two-entry request queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (q_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= in_req;
  end
endmodule
`default_nettype wire

/* rtl/acm_issue.sv */
`default_nettype none
module acm_issue #(
  parameter int BLOCKS_PER_ITEM = acm_pkg::ACM_BLOCKS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 q_valid,
  input  wire acm_pkg::acm_in_req_t q_req,
  output logic                      q_pop,
  output logic                      st_valid,
  output acm_pkg::acm_stage_t       st_p
);
  import acm_pkg::*;

  localparam logic [1:0] LAST_IDX = 2'(BLOCKS_PER_ITEM - 1);

  logic         cur_v_r;
  logic [255:0] key_r;
  logic [127:0] ctr_r;
  logic [1:0]   cnt_r;
  logic         eos_r;
  logic         st_v_r;
  acm_stage_t   st_r;
  logic         is_last, fire;

  assign is_last = (cnt_r == LAST_IDX);
  assign fire    = en && cur_v_r;
  assign q_pop   = q_valid && (!cur_v_r || (fire && is_last));

  // current item: counter steps once per issued block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      cnt_r   <= 2'd0;
    end else if (q_pop) begin
      cur_v_r <= 1'b1;
      cnt_r   <= 2'd0;
    end else if (fire) begin
      if (is_last) cur_v_r <= 1'b0;
      cnt_r <= cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      key_r <= {q_req.key_word_3, q_req.key_word_2, q_req.key_word_1, q_req.key_word_0};
      ctr_r <= {q_req.counter_high, q_req.counter_low};
      eos_r <= q_req.end_of_stream;
    end else if (fire) begin
      ctr_r <= ctr_r + 128'd1;
    end
  end

  // entry stage: initial round key added
  always_ff @(posedge clk) begin
    if (!rst_n) st_v_r <= 1'b0;
    else if (en) st_v_r <= cur_v_r;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      st_r.state <= ctr_r ^ key_r[127:0];
      st_r.win   <= key_r;
      st_r.idx   <= cnt_r;
      st_r.last  <= is_last;
      st_r.eos   <= is_last && eos_r;
    end
  end

  assign st_valid = st_v_r;
  assign st_p     = st_r;
endmodule
`default_nettype wire

/* rtl/acm_round.sv */
`default_nettype none
module acm_round #(
  parameter int ROUND = 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                i_valid,
  input  wire acm_pkg::acm_stage_t i_p,
  output logic                     o_valid,
  output acm_pkg::acm_stage_t      o_p
);
  import acm_pkg::*;

  localparam logic       ROT = ((ROUND % 2) == 1);
  localparam int         RCI = (ROUND + 1) / 2 - 1;
  localparam logic [7:0] RC  = RCON[RCI];

  logic       v_r;
  acm_stage_t p_r;
  logic [127:0] sh;

  assign sh = sub_shift(i_p.state);

  // one cipher round plus four new key words
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (en) v_r <= i_valid;
  end

  always_ff @(posedge clk) begin
    if (en && i_valid) begin
      p_r.state <= ((ROUND == ACM_ROUNDS) ? sh : mix_cols(sh)) ^ i_p.win[255:128];
      p_r.win   <= next_win(i_p.win, ROT, RC);
      p_r.idx   <= i_p.idx;
      p_r.last  <= i_p.last;
      p_r.eos   <= i_p.eos;
    end
  end

  assign o_valid = v_r;
  assign o_p     = p_r;
endmodule
`default_nettype wire

/* rtl/aes256_counter_block_mixer.sv */
// Channel | Ports                        | Moves
// input   | in_valid, in_stall, in_req   | key and counter request, one per item
// output  | out_valid, out_stall, out_req| BLOCKS_PER_ITEM blocks per request
//
// Each item issues BLOCKS_PER_ITEM blocks, one per cycle unless a held output stalls
// the pipeline; a two-entry queue takes requests meanwhile.
// From issue to out_valid a block passes the entry stage and 14 round stages.
// Reset clears the queue and all stage valids; no clearing pass.
// A held output freezes the whole pipeline; in_stall rises when the queue is full.
`default_nettype none
module aes256_counter_block_mixer #(
  parameter int BLOCKS_PER_ITEM = acm_pkg::ACM_BLOCKS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire acm_pkg::acm_in_req_t  in_req,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output acm_pkg::acm_out_req_t      out_req
);
  import acm_pkg::*;

  logic        q_valid, q_pop, en;
  acm_in_req_t q_req;
  logic        st_v [0:ACM_ROUNDS];
  acm_stage_t  st_p [0:ACM_ROUNDS];

  // pipeline advances unless a finished block is held
  assign en = !(out_valid && out_stall);

  acm_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_req,
    .q_valid, .q_req, .q_pop
  );

  acm_issue #(.BLOCKS_PER_ITEM(BLOCKS_PER_ITEM)) u_issue (
    .clk, .rst_n, .en, .q_valid, .q_req, .q_pop,
    .st_valid(st_v[0]), .st_p(st_p[0])
  );

  for (genvar r = 1; r <= ACM_ROUNDS; r++) begin : g_rnd
    acm_round #(.ROUND(r)) u_round (
      .clk, .rst_n, .en,
      .i_valid(st_v[r-1]), .i_p(st_p[r-1]),
      .o_valid(st_v[r]),   .o_p(st_p[r])
    );
  end

  assign out_valid            = st_v[ACM_ROUNDS];
  assign out_req.block_low    = st_p[ACM_ROUNDS].state[63:0];
  assign out_req.block_high   = st_p[ACM_ROUNDS].state[127:64];
  assign out_req.block_index  = st_p[ACM_ROUNDS].idx;
  assign out_req.last_of_item = st_p[ACM_ROUNDS].last;
  assign out_req.stream_end   = st_p[ACM_ROUNDS].eos;
endmodule
`default_nettype wire

/* rtl/acm_checker.sv */
`default_nettype none
`include "aes256_counter_block_mixer_macros.svh"
module acm_checker #(
  parameter int BLOCKS_PER_ITEM = acm_pkg::ACM_BLOCKS_DEF
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire acm_pkg::acm_out_req_t out_req
);

  // held result stays put
  `ACM_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(out_req))
  // stream end only on the closing block
  `ACM_ASSERT_IMP(a_eos, out_valid && !out_req.last_of_item, !out_req.stream_end)
  // closing block carries the top offset
  `ACM_ASSERT_IMP(a_lastidx, out_valid && out_req.last_of_item,
                  out_req.block_index == 2'(BLOCKS_PER_ITEM - 1))
  // offsets stay in range
  `ACM_ASSERT_IMP(a_range, out_valid, out_req.block_index <= 2'(BLOCKS_PER_ITEM - 1))
endmodule

bind aes256_counter_block_mixer acm_checker #(.BLOCKS_PER_ITEM(BLOCKS_PER_ITEM)) u_acm_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_req
);
`default_nettype wire
